// File: rtl/rhcs_pkg.sv
package rhcs_pkg;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_POLL_PERIOD = 2'd0,
        CFG_NEAR_WINDOW = 2'd1,
        CFG_FAR_WINDOW  = 2'd2
    } rhcs_cfg_e;

    // Command codes of an input item
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } rhcs_cmd_e;

    localparam int CHAN_W  = 7;
    localparam int TIMER_W = 8;
    localparam int TIDX_W  = 4;

    localparam logic [TIMER_W-1:0] TIMER_MAX       = 8'd255;
    localparam logic [TIMER_W-1:0] POLL_PERIOD_RST = 8'd5;
    localparam logic [TIMER_W-1:0] NEAR_WINDOW_RST = 8'd50;
    localparam logic [TIMER_W-1:0] FAR_WINDOW_RST  = 8'd100;

    localparam logic [CHAN_W-1:0] CHAN_RST      = 7'd46;
    localparam logic [CHAN_W-1:0] NEXT_RST      = 7'd70;
    localparam logic [CHAN_W-1:0] NEXT_NEXT_RST = 7'd62;

    // Hop table contents after reset repeat this four-entry pattern
    localparam logic [CHAN_W-1:0] HOP_PATTERN [4] = '{7'd46, 7'd70, 7'd62, 7'd54};

    typedef struct packed {
        logic                command;
        logic                rx_data_ready;
        logic                clear_ready;
        logic [TIDX_W-1:0]   table_index;
        logic [CHAN_W-1:0]   table_value;
    } rhcs_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic                channel_written;
        logic                payload_fetch;
        logic                rx_ready;
        logic                poll_done;
    } rhcs_result_t;

    typedef struct packed {
        logic [TIMER_W-1:0]  poll_period;
        logic [TIMER_W-1:0]  near_window;
        logic [TIMER_W-1:0]  far_window;
    } rhcs_cfg_t;

    // Table entry at an address that has not been loaded since reset
    function automatic logic [CHAN_W-1:0] reset_channel(input logic [1:0] slot);
        return HOP_PATTERN[slot];
    endfunction

endpackage

// File: rtl/rhcs_table_ram.sv
module rhcs_table_ram #(
    parameter int DEPTH       = 16,
    parameter int RESET_SLOT  = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [rhcs_pkg::CHAN_W-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [rhcs_pkg::CHAN_W-1:0]         rd_data
);
    import rhcs_pkg::*;

    localparam int RESET_ADDR = RESET_SLOT % DEPTH;
    localparam logic [1:0] RESET_PAT = 2'(RESET_ADDR % 4);

    logic [CHAN_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  loaded_reg;
    logic [DEPTH-1:0]  loaded_next;
    logic [CHAN_W-1:0] rd_data_reg;

    // Mark entries that have been loaded since reset
    always_comb
    begin
        loaded_next = loaded_reg;
        if (wr_en)
        begin
            loaded_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else
        begin
            loaded_reg <= loaded_next;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a write to the same address in the same cycle is forwarded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_data_reg <= reset_channel(RESET_PAT);
        end
        else if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else if (loaded_reg[rd_addr])
        begin
            rd_data_reg <= mem[rd_addr];
        end
        else
        begin
            rd_data_reg <= reset_channel(rd_addr[1:0]);
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/rhcs_step_core.sv
module rhcs_step_core #(
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    exec,
    input  rhcs_pkg::rhcs_item_t    item,
    input  rhcs_pkg::rhcs_cfg_t     cfg,
    output rhcs_pkg::rhcs_result_t  result
);
    import rhcs_pkg::*;

    localparam int AW = $clog2(CHANNEL_COUNT);
    localparam logic [AW:0] COUNT_W = (AW+1)'(CHANNEL_COUNT);
    localparam logic [6:0]  COUNT_IDX = 7'(CHANNEL_COUNT);

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
        logic [AW:0] n;
        n = {1'b0, p} + 1'b1;
        return (n >= COUNT_W) ? '0 : n[AW-1:0];
    endfunction

    logic [TIMER_W-1:0] poll_timer_reg,  poll_timer_next;
    logic [TIMER_W-1:0] hop_timer_reg,   hop_timer_next;
    logic               ready_flag_reg,  ready_flag_next;
    logic               alt_flag_reg,    alt_flag_next;
    logic [CHAN_W-1:0]  cur_chan_reg,    cur_chan_next;
    logic [AW-1:0]      hop_pos_reg,     hop_pos_next;
    logic [CHAN_W-1:0]  eff_chan_reg,    eff_chan_next;
    logic [CHAN_W-1:0]  next_chan_reg,   next_chan_next;
    logic [CHAN_W-1:0]  nn_chan_reg,     nn_chan_next;

    logic [TIMER_W-1:0] poll_inc;
    logic [TIMER_W-1:0] hop_inc;
    logic [6:0]         tidx_w;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               written;
    logic               fetch;
    logic               polled;

    logic [AW-1:0]      rd_addr [3];
    logic [CHAN_W-1:0]  tab     [3];

    // Table copies, one per read offset from the hop position
    for (genvar k = 0; k < 3; k++)
    begin : g_tab
        rhcs_table_ram #(
            .DEPTH      (CHANNEL_COUNT),
            .RESET_SLOT (k)
        ) u_ram (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (item.table_value),
            .rd_addr (rd_addr[k]),
            .rd_data (tab[k])
        );
    end

    // Read ahead at the position the next item will see
    always_comb
    begin
        rd_addr[0] = hop_pos_next;
        rd_addr[1] = wrap_next(rd_addr[0]);
        rd_addr[2] = wrap_next(rd_addr[1]);
    end

    assign poll_inc = (poll_timer_reg == TIMER_MAX) ? poll_timer_reg : poll_timer_reg + 1'b1;
    assign hop_inc  = (hop_timer_reg == TIMER_MAX) ? hop_timer_reg : hop_timer_reg + 1'b1;
    assign tidx_w   = {3'b000, item.table_index};
    assign wr_addr  = tidx_w[AW-1:0];

    // Step one item: load a table entry or run one tick
    always_comb
    begin
        poll_timer_next = poll_timer_reg;
        hop_timer_next  = hop_timer_reg;
        ready_flag_next = ready_flag_reg;
        alt_flag_next   = alt_flag_reg;
        cur_chan_next   = cur_chan_reg;
        hop_pos_next    = hop_pos_reg;
        eff_chan_next   = eff_chan_reg;
        next_chan_next  = next_chan_reg;
        nn_chan_next    = nn_chan_reg;
        wr_en           = 1'b0;
        written         = 1'b0;
        fetch           = 1'b0;
        polled          = 1'b0;

        if (exec)
        begin
            if (item.clear_ready)
            begin
                ready_flag_next = 1'b0;
            end

            if (item.command == CMD_LOAD)
            begin
                wr_en = (tidx_w < COUNT_IDX);
            end
            else
            begin
                poll_timer_next = poll_inc;
                hop_timer_next  = hop_inc;

                if (poll_inc >= cfg.poll_period)
                begin
                    poll_timer_next = '0;
                    polled          = 1'b1;

                    // Packet found: resync the table position to the channel
                    if (item.rx_data_ready)
                    begin
                        fetch           = 1'b1;
                        ready_flag_next = 1'b1;
                        hop_timer_next  = '0;
                        alt_flag_next   = 1'b0;
                        if (cur_chan_reg != tab[0])
                        begin
                            if (cur_chan_reg == next_chan_reg)
                            begin
                                hop_pos_next = wrap_next(hop_pos_reg);
                            end
                            else if (cur_chan_reg == nn_chan_reg)
                            begin
                                hop_pos_next = wrap_next(wrap_next(hop_pos_reg));
                            end
                        end
                        eff_chan_next = cur_chan_reg;
                    end

                    // No packet pending: pick the next channel
                    if (!ready_flag_next)
                    begin
                        next_chan_next = tab[1];
                        nn_chan_next   = tab[2];
                        if (hop_inc < cfg.near_window)
                        begin
                            cur_chan_next = alt_flag_reg ? tab[1] : eff_chan_reg;
                        end
                        else if (hop_inc < cfg.far_window)
                        begin
                            cur_chan_next = alt_flag_reg ? tab[2] : tab[1];
                        end
                        else
                        begin
                            hop_timer_next = cfg.far_window;
                            hop_pos_next   = wrap_next(hop_pos_reg);
                            cur_chan_next  = tab[1];
                        end
                        alt_flag_next = !alt_flag_reg;
                        written       = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_timer_reg <= '0;
            hop_timer_reg  <= '0;
            ready_flag_reg <= 1'b0;
            alt_flag_reg   <= 1'b0;
            cur_chan_reg   <= CHAN_RST;
            hop_pos_reg    <= '0;
            eff_chan_reg   <= CHAN_RST;
            next_chan_reg  <= NEXT_RST;
            nn_chan_reg    <= NEXT_NEXT_RST;
        end
        else
        begin
            poll_timer_reg <= poll_timer_next;
            hop_timer_reg  <= hop_timer_next;
            ready_flag_reg <= ready_flag_next;
            alt_flag_reg   <= alt_flag_next;
            cur_chan_reg   <= cur_chan_next;
            hop_pos_reg    <= hop_pos_next;
            eff_chan_reg   <= eff_chan_next;
            next_chan_reg  <= next_chan_next;
            nn_chan_reg    <= nn_chan_next;
        end
    end

    // Result of this step
    always_comb
    begin
        result.channel         = cur_chan_next;
        result.channel_written = written;
        result.payload_fetch   = fetch;
        result.rx_ready        = ready_flag_next;
        result.poll_done       = polled;
    end

endmodule

// File: rtl/rx_hop_channel_sequencer.sv
// Receiver hop sequencer: one result per accepted item (tick or table load). An item
// passes an input register, is stepped against the timers, flags and channel registers,
// and lands in a result register, so with out_ready held high a new item is taken
// every cycle. The hop table is kept in three register-file copies, each read at one
// offset from the position the next item will see, so a table load is visible to the
// very next item.
// Configuration writes are taken at any time on the cfg port (cfg_ready is always high)
// and should be made while no item is in flight.
module rx_hop_channel_sequencer #(
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic                              rx_data_ready,
    input  logic                              clear_ready,
    input  logic [rhcs_pkg::TIDX_W-1:0]       table_index,
    input  logic [rhcs_pkg::CHAN_W-1:0]       table_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rhcs_pkg::CHAN_W-1:0]       channel,
    output logic                              channel_written,
    output logic                              payload_fetch,
    output logic                              rx_ready,
    output logic                              poll_done,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [rhcs_pkg::TIMER_W-1:0]      cfg_data
);
    import rhcs_pkg::*;

    rhcs_item_t   in_reg;
    logic         in_valid_reg,  in_valid_next;
    rhcs_result_t out_reg;
    logic         out_valid_reg, out_valid_next;
    rhcs_cfg_t    cfg_reg,       cfg_next;
    rhcs_result_t step_result;
    logic         exec_fire;
    logic         in_xfer;

    assign exec_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || exec_fire;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POLL_PERIOD: cfg_next.poll_period = cfg_data;
                CFG_NEAR_WINDOW: cfg_next.near_window = cfg_data;
                CFG_FAR_WINDOW:  cfg_next.far_window  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_period <= POLL_PERIOD_RST;
            cfg_reg.near_window <= NEAR_WINDOW_RST;
            cfg_reg.far_window  <= FAR_WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register: hold the item until the step stage takes it
    assign in_valid_next = in_xfer ? 1'b1 : (exec_fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_reg.command       <= command;
            in_reg.rx_data_ready <= rx_data_ready;
            in_reg.clear_ready   <= clear_ready;
            in_reg.table_index   <= table_index;
            in_reg.table_value   <= table_value;
        end
    end

    rhcs_step_core #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (exec_fire),
        .item   (in_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    // Result register: hold until the transfer on the output side
    assign out_valid_next = exec_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign channel         = out_reg.channel;
    assign channel_written = out_reg.channel_written;
    assign payload_fetch   = out_reg.payload_fetch;
    assign rx_ready        = out_reg.rx_ready;
    assign poll_done       = out_reg.poll_done;

endmodule

// File: rtl/rhcs_checker.sv
module rhcs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [rhcs_pkg::CHAN_W-1:0]       channel,
    input  logic                              channel_written,
    input  logic                              payload_fetch,
    input  logic                              rx_ready,
    input  logic                              poll_done
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(rx_ready))
        else $error("result dropped or changed while stalled");

    // Stall the input side only behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while the result side is free");

    // Drive a hop or a fetch only on an evaluation
    a_hop_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (channel_written || payload_fetch) |-> poll_done)
        else $error("hop or fetch without an evaluation");

    // Keep a fetch from hopping, and raise the ready flag with it
    a_fetch_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_fetch |-> rx_ready && !channel_written)
        else $error("fetch without ready flag, or fetch with a hop");

endmodule

bind rx_hop_channel_sequencer rhcs_checker u_rhcs_checker (.*);
